[hdl/inverse_cdf_angle_sampler_assert.svh]
// Assertion macros shared by the sampler RTL.
// Each macro checks on the rising edge of aclk and is quiet while aresetn is low.
`ifndef INVERSE_CDF_ANGLE_SAMPLER_ASSERT_SVH
`define INVERSE_CDF_ANGLE_SAMPLER_ASSERT_SVH

// Same-cycle implication.
`define ICAS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ICAS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/icas_pkg.sv]
`default_nettype none
package icas_pkg;

    localparam int MAX_BINS_DEF = 256;
    localparam int CFG_AW       = 4;
    localparam int BIN_DW       = 81;   // fraction 17 + energy 32 + speed 32
    localparam int DIV_W        = 64;

    localparam logic [6:0] DIV_STEPS = 7'd64;

    // register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_BIN_WIDTH    = 2'd0;
    localparam logic [1:0] REG_BINS_IN_USE  = 2'd1;
    localparam logic [1:0] REG_BEAM_MODE    = 2'd2;
    localparam logic [1:0] REG_BEAM_AZIMUTH = 2'd3;

    localparam logic [28:0] BIN_WIDTH_RST = 29'd4685083;
    localparam logic [8:0]  BINS_RST      = 9'd256;

    localparam logic [28:0] HALF_PI_Q28 = 29'd421657428;
    localparam logic [29:0] PI_Q28      = 30'd843314857;
    localparam logic [30:0] TWO_PI_Q28  = 31'd1686629713;
    localparam logic [31:0] SQRT2_Q31   = 32'd3037000500;
    localparam logic [32:0] SAT33       = 33'h1_FFFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_BIN,
        ST_RD1,
        ST_RD2,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_MUL5,
        ST_WAITQ,
        ST_FOLD,
        ST_WAITE,
        ST_DONE
    } icas_state_t;

endpackage
`default_nettype wire

[hdl/icas_ram.sv]
`default_nettype none
module icas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]              rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write one word, read one word through a registered read port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[hdl/inverse_cdf_angle_sampler.sv]
`default_nettype none
// Inverse-CDF angle sampler. Load beats (op 0) write one cumulative entry and one bin's
// fraction, energy and speed in the same cycle. A sample beat (op 1) scans the cumulative
// table one entry per cycle through its memory read port (n+1 reads, n = bins_in_use
// clamped to 1..MAX_BINS), then runs two 64-step bit-serial divisions on a shared divider
// (interpolated angle, then energy). It holds s_ready low, taking no new beat, until its
// result is moved to the output register, once that register holds no unaccepted result.
// A finished result waits in the output register while the next beat is taken.
// The user must write configuration over APB only while the block is idle; the block
// does not enforce it. Table entries that were never loaded read back as arbitrary values.
`include "inverse_cdf_angle_sampler_assert.svh"
module inverse_cdf_angle_sampler #(
    parameter int MAX_BINS = icas_pkg::MAX_BINS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // configuration
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [icas_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // input channel
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_op,
    input  wire logic [8:0]                s_entry_index,
    input  wire logic [31:0]               s_entry_cum,
    input  wire logic [16:0]               s_entry_fraction,
    input  wire logic [31:0]               s_entry_energy,
    input  wire logic [31:0]               s_entry_speed,
    input  wire logic [31:0]               s_rand_angle,
    input  wire logic [31:0]               s_rand_azimuth,
    input  wire logic [31:0]               s_rand_charge,
    // result channel
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [28:0]                    m_polar_angle,
    output logic [30:0]                    m_azimuth,
    output logic                           m_double_charged,
    output logic [32:0]                    m_ion_energy,
    output logic [32:0]                    m_ion_speed
);
    import icas_pkg::*;

    localparam int CUM_DEPTH = MAX_BINS + 1;
    localparam int CUM_AW    = $clog2(CUM_DEPTH);
    localparam int BIN_AW    = $clog2(MAX_BINS);
    localparam int CNT_W     = $clog2(MAX_BINS + 2);
    localparam logic [CNT_W-1:0] ONE_C = 1;

    // configuration registers
    logic [28:0] bin_width_reg;
    logic [8:0]  bins_in_use_reg;
    logic        beam_mode_reg;
    logic [30:0] beam_azimuth_reg;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_width_reg    <= BIN_WIDTH_RST;
            bins_in_use_reg  <= BINS_RST;
            beam_mode_reg    <= 1'b0;
            beam_azimuth_reg <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_BIN_WIDTH:    bin_width_reg    <= pwdata[28:0];
                REG_BINS_IN_USE:  bins_in_use_reg  <= pwdata[8:0];
                REG_BEAM_MODE:    beam_mode_reg    <= pwdata[0];
                REG_BEAM_AZIMUTH: beam_azimuth_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[3:2])
            REG_BIN_WIDTH:    prdata = {3'd0, bin_width_reg};
            REG_BINS_IN_USE:  prdata = {23'd0, bins_in_use_reg};
            REG_BEAM_MODE:    prdata = {31'd0, beam_mode_reg};
            REG_BEAM_AZIMUTH: prdata = {1'b0, beam_azimuth_reg};
            default:          prdata = '0;
        endcase
    end

    // state and datapath registers
    icas_state_t state_reg, state_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic             rdv_reg, rdv_next;
    logic [31:0]      ra_reg, rz_reg, rc_reg;
    logic [31:0]      cum0_reg;
    logic [16:0]      frac_reg;
    logic [31:0]      energy_reg;
    logic [31:0]      speed_reg;
    logic signed [32:0] d_reg;
    logic             dbl_reg;
    logic             q_neg_reg, q_zero_reg;
    logic signed [65:0] base_reg, t_reg;
    logic [30:0]      az_reg;
    logic [32:0]      spd_out_reg;
    logic [28:0]      polar_reg;
    logic [32:0]      egy_out_reg;
    logic signed [67:0] prod_reg;
    logic             m_valid_reg;
    logic [28:0]      m_polar_reg;
    logic [30:0]      m_az_reg;
    logic             m_dbl_reg;
    logic [32:0]      m_egy_reg;
    logic [32:0]      m_spd_reg;

    // divider registers
    logic [DIV_W-1:0] dv_quo_reg;
    logic [31:0]      dv_rem_reg;
    logic [31:0]      dv_den_reg;
    logic [6:0]       dv_cnt_reg;
    logic             dv_load;
    logic [DIV_W-1:0] dv_num;
    logic [31:0]      dv_den;

    logic out_load;
    logic signed [33:0] mul_a, mul_b;

    // memories
    logic              cum_we, bin_we;
    logic [CUM_AW-1:0] cum_raddr;
    logic [BIN_AW-1:0] bin_raddr;
    logic [31:0]       cum_rdata;
    logic [BIN_DW-1:0] bin_rdata;
    logic [31:0]       idx32;
    logic              load_acc;

    assign s_ready  = (state_reg == ST_IDLE);
    assign load_acc = s_valid && s_ready && !s_op;
    assign idx32    = {23'd0, s_entry_index};
    assign cum_we   = load_acc && (idx32 <= 32'(MAX_BINS));
    assign bin_we   = load_acc && (idx32 < 32'(MAX_BINS));

    icas_ram #(.WIDTH(32), .DEPTH(CUM_DEPTH)) u_cum_ram (
        .clk     (aclk),
        .wr_en   (cum_we),
        .wr_addr (idx32[CUM_AW-1:0]),
        .wr_data (s_entry_cum),
        .rd_addr (cum_raddr),
        .rd_data (cum_rdata)
    );

    icas_ram #(.WIDTH(BIN_DW), .DEPTH(MAX_BINS)) u_bin_ram (
        .clk     (aclk),
        .wr_en   (bin_we),
        .wr_addr (idx32[BIN_AW-1:0]),
        .wr_data ({s_entry_fraction, s_entry_energy, s_entry_speed}),
        .rd_addr (bin_raddr),
        .rd_data (bin_rdata)
    );

    // bin count clamp and bin index
    logic [31:0]      n_full;
    logic [CNT_W-1:0] n, n_m1, ic, i_sel, spd_idx, i_p1;
    assign n_full = (bins_in_use_reg == '0) ? 32'd1 :
                    (({23'd0, bins_in_use_reg} > 32'(MAX_BINS)) ? 32'(MAX_BINS)
                                                                : {23'd0, bins_in_use_reg});
    assign n       = n_full[CNT_W-1:0];
    assign n_m1    = n - ONE_C;
    assign ic      = (cnt_reg == '0) ? '0 : cnt_reg - ONE_C;
    assign i_sel   = (ic > n_m1) ? n_m1 : ic;
    assign spd_idx = (i_reg == '0) ? '0 : i_reg - ONE_C;
    assign i_p1    = i_reg + ONE_C;

    // arithmetic helpers
    logic signed [32:0] diff33, d33, d_abs;
    logic signed [64:0] num65, num_abs;
    logic signed [33:0] i_ext, twoi_m1;
    logic signed [65:0] quo66, q66, t_sum;
    logic [65:0]        t_abs;
    logic [64:0]        t_half, pi_sub;
    logic [28:0]        polar_val;
    logic [64:0]        spd_rnd;
    logic [32:0]        spd_sat, egy_sat;

    assign diff33  = $signed({1'b0, ra_reg}) - $signed({1'b0, cum0_reg});
    assign d33     = $signed({1'b0, cum_rdata}) - $signed({1'b0, cum0_reg});
    assign d_abs   = d_reg[32] ? -d_reg : d_reg;
    assign num65   = $signed({prod_reg[63:0], 1'b0});
    assign num_abs = prod_reg[67] ? -num65 : num65;
    assign i_ext   = $signed({{(34-CNT_W){1'b0}}, i_reg});
    assign twoi_m1 = (i_ext <<< 1) - 34'sd1;
    assign quo66   = $signed({2'b00, dv_quo_reg});
    assign q66     = q_zero_reg ? '0 : (q_neg_reg ? -quo66 : quo66);
    assign t_sum   = base_reg + q66;
    assign t_abs   = t_reg[65] ? 66'(-t_reg) : 66'(t_reg);
    assign t_half  = t_abs[65:1];
    assign pi_sub  = {35'd0, PI_Q28} - t_half;
    assign spd_rnd = prod_reg[64:0] + {34'd0, 1'b1, 30'd0};
    assign spd_sat = (spd_rnd[64:31] > {1'b0, SAT33}) ? SAT33 : spd_rnd[63:31];
    assign egy_sat = (dv_quo_reg > {31'd0, SAT33}) ? SAT33 : dv_quo_reg[32:0];

    // fold the angle about pi/2
    always_comb begin
        if (t_half > {36'd0, HALF_PI_Q28}) begin
            polar_val = (t_half >= {35'd0, PI_Q28}) ? '0 : pi_sub[28:0];
        end else begin
            polar_val = t_half[28:0];
        end
    end

    // bit-serial restoring divider step
    logic [32:0] dv_sh, dv_sub;
    logic        dv_ge;
    assign dv_sh  = {dv_rem_reg, dv_quo_reg[DIV_W-1]};
    assign dv_ge  = dv_sh >= {1'b0, dv_den_reg};
    assign dv_sub = dv_sh - {1'b0, dv_den_reg};

    // sequencer: next state, memory addresses, multiplier operands, divider loads
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        rdv_next   = 1'b0;
        cum_raddr  = idx32[CUM_AW-1:0];
        bin_raddr  = i_sel[BIN_AW-1:0];
        mul_a      = '0;
        mul_b      = '0;
        dv_load    = 1'b0;
        dv_num     = num_abs[DIV_W-1:0];
        dv_den     = d_abs[31:0];
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_op) begin
                    k_next     = '0;
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // issue one read per cycle, count entries below the random value
                cum_raddr = k_reg[CUM_AW-1:0];
                if (k_reg <= n) begin
                    k_next   = k_reg + ONE_C;
                    rdv_next = 1'b1;
                end
                if (rdv_reg && (cum_rdata < ra_reg)) begin
                    cnt_next = cnt_reg + ONE_C;
                end
                if ((k_reg > n) && !rdv_reg) begin
                    state_next = ST_BIN;
                end
            end
            ST_BIN: begin
                cum_raddr  = i_sel[CUM_AW-1:0];
                bin_raddr  = i_sel[BIN_AW-1:0];
                i_next     = i_sel;
                state_next = ST_RD1;
            end
            ST_RD1: begin
                cum_raddr  = i_p1[CUM_AW-1:0];
                bin_raddr  = spd_idx[BIN_AW-1:0];
                state_next = ST_RD2;
            end
            ST_RD2: begin
                mul_a      = $signed({5'd0, bin_width_reg});
                mul_b      = $signed({diff33[32], diff33});
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                dv_load    = 1'b1;
                mul_a      = $signed({5'd0, bin_width_reg});
                mul_b      = twoi_m1;
                state_next = ST_MUL3;
            end
            ST_MUL3: begin
                mul_a      = $signed({3'd0, TWO_PI_Q28});
                mul_b      = $signed({2'd0, rz_reg});
                state_next = ST_MUL4;
            end
            ST_MUL4: begin
                mul_a      = $signed({2'd0, SQRT2_Q31});
                mul_b      = $signed({2'd0, speed_reg});
                state_next = ST_MUL5;
            end
            ST_MUL5: begin
                state_next = ST_WAITQ;
            end
            ST_WAITQ: begin
                if (dv_cnt_reg == '0) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                dv_load    = 1'b1;
                dv_num     = dbl_reg ? {15'd0, energy_reg, 17'd0} : {16'd0, energy_reg, 16'd0};
                dv_den     = 32'd65536 + {15'd0, frac_reg};
                state_next = ST_WAITE;
            end
            ST_WAITE: begin
                if (dv_cnt_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rdv_reg     <= 1'b0;
            dv_cnt_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rdv_reg   <= rdv_next;
            if (dv_load) begin
                dv_cnt_reg <= DIV_STEPS;
            end else if (dv_cnt_reg != '0) begin
                dv_cnt_reg <= dv_cnt_reg - 7'd1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        k_reg    <= k_next;
        cnt_reg  <= cnt_next;
        i_reg    <= i_next;
        prod_reg <= 68'(mul_a) * 68'(mul_b);
        if (s_valid && s_ready && s_op) begin
            ra_reg <= s_rand_angle;
            rz_reg <= s_rand_azimuth;
            rc_reg <= s_rand_charge;
        end
        case (state_reg)
            ST_RD1: begin
                cum0_reg   <= cum_rdata;
                frac_reg   <= bin_rdata[80:64];
                energy_reg <= bin_rdata[63:32];
            end
            ST_RD2: begin
                d_reg     <= d33;
                speed_reg <= bin_rdata[31:0];
                dbl_reg   <= {1'b0, rc_reg} < {frac_reg, 16'd0};
            end
            ST_MUL2: begin
                q_neg_reg  <= prod_reg[67] ^ d_reg[32];
                q_zero_reg <= (d_reg == '0);
            end
            ST_MUL3: base_reg <= prod_reg[65:0];
            ST_MUL4: az_reg <= beam_mode_reg ? beam_azimuth_reg : prod_reg[62:32];
            ST_MUL5: spd_out_reg <= dbl_reg ? spd_sat : {1'b0, speed_reg};
            ST_WAITQ: t_reg <= t_sum;
            ST_FOLD: polar_reg <= polar_val;
            ST_WAITE: egy_out_reg <= egy_sat;
            default: ;
        endcase
        // divider
        if (dv_load) begin
            dv_quo_reg <= dv_num;
            dv_rem_reg <= '0;
            dv_den_reg <= dv_den;
        end else if (dv_cnt_reg != '0) begin
            dv_rem_reg <= dv_ge ? dv_sub[31:0] : dv_sh[31:0];
            dv_quo_reg <= {dv_quo_reg[DIV_W-2:0], dv_ge};
        end
        // output register
        if (out_load) begin
            m_polar_reg <= polar_reg;
            m_az_reg    <= az_reg;
            m_dbl_reg   <= dbl_reg;
            m_egy_reg   <= egy_out_reg;
            m_spd_reg   <= spd_out_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_polar_angle    = m_polar_reg;
    assign m_azimuth        = m_az_reg;
    assign m_double_charged = m_dbl_reg;
    assign m_ion_energy     = m_egy_reg;
    assign m_ion_speed      = m_spd_reg;

    `ICAS_ASSERT_NEXT(a_sample_starts_scan, s_valid && s_ready && s_op, state_reg == ST_SCAN, "sample beat did not start the table scan")
    `ICAS_ASSERT_NOW(a_div_free_on_load, dv_load, dv_cnt_reg == '0, "divider loaded while still busy")
    `ICAS_ASSERT_NOW(a_bin_in_range, state_reg == ST_RD1, i_reg < n, "bin index beyond loaded bins")
    `ICAS_ASSERT_NEXT(a_result_waits, (state_reg == ST_DONE) && m_valid_reg && !m_ready, state_reg == ST_DONE, "result overwrote a pending beat")

endmodule
`default_nettype wire

[verif/tb.sv]
module tb;
    import icas_pkg::*;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;
    localparam int   TBL_BINS  = 256;
    localparam int   IDLE_WAIT = 600;
    localparam int   LONG_HOLD = 3000;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct {
        logic        op;
        logic [8:0]  entry_index;
        logic [31:0] entry_cum;
        logic [16:0] entry_fraction;
        logic [31:0] entry_energy;
        logic [31:0] entry_speed;
        logic [31:0] rand_angle;
        logic [31:0] rand_azimuth;
        logic [31:0] rand_charge;
    } beat_t;

    typedef struct packed {
        logic [28:0] polar_angle;
        logic [30:0] azimuth;
        logic        double_charged;
        logic [32:0] ion_energy;
        logic [32:0] ion_speed;
    } ion_t;

    // Tracks the sampler tables and registers and predicts each drawn ion.
    class ion_scoreboard;
        bit [31:0] cum_tab[TBL_BINS+1];
        bit [16:0] frac_tab[TBL_BINS];
        bit [31:0] energy_tab[TBL_BINS];
        bit [31:0] speed_tab[TBL_BINS];
        bit [28:0] bin_width = BIN_WIDTH_RST;
        bit [8:0]  bins_in_use = BINS_RST;
        bit        beam_mode = 1'b0;
        bit [30:0] beam_azimuth = '0;
        ion_t      expected_ions[$];
        int        mismatches = 0;
        int        checked = 0;

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_BIN_WIDTH:    bin_width = val[28:0];
                REG_BINS_IN_USE:  bins_in_use = val[8:0];
                REG_BEAM_MODE:    beam_mode = val[0];
                REG_BEAM_AZIMUTH: beam_azimuth = val[30:0];
                default: ;
            endcase
        endfunction

        function void note_beat(beat_t b);
            longint n, c, i, d, q, t, w, ra;
            longint unsigned az, frac, energy, speed;
            bit dbl;
            ion_t e;
            // table write: index above the top is dropped, the top takes only cum
            if (b.op == OP_LOAD) begin
                if (b.entry_index <= TBL_BINS) cum_tab[b.entry_index] = b.entry_cum;
                if (b.entry_index < TBL_BINS) begin
                    frac_tab[b.entry_index] = b.entry_fraction;
                    energy_tab[b.entry_index] = b.entry_energy;
                    speed_tab[b.entry_index] = b.entry_speed;
                end
                return;
            end
            n = bins_in_use;
            if (n < 1) n = 1;
            if (n > TBL_BINS) n = TBL_BINS;
            ra = longint'({32'd0, b.rand_angle});
            c = 0;
            for (int k = 0; k <= n; k++)
                if (longint'({32'd0, cum_tab[k]}) < ra) c++;
            i = c - 1;
            if (i < 0) i = 0;
            if (i > n - 1) i = n - 1;
            w = longint'({35'd0, bin_width});
            d = longint'({32'd0, cum_tab[i+1]}) - longint'({32'd0, cum_tab[i]});
            // interpolate inside the bin; an empty bin adds nothing
            q = (d == 0) ? 0 : (2 * w * (ra - longint'({32'd0, cum_tab[i]}))) / d;
            t = w * (2 * i - 1) + q;
            if (t < 0) t = -t;
            t = t / 2;
            if (t > longint'(HALF_PI_Q28))
                t = (t >= longint'(PI_Q28)) ? 0 : longint'(PI_Q28) - t;
            if (beam_mode) az = beam_azimuth;
            else az = (longint'({32'd0, b.rand_azimuth}) * longint'(TWO_PI_Q28)) >> 32;
            frac = frac_tab[i];
            dbl = ({32'd0, b.rand_charge} < (frac << 16));
            energy = ({32'd0, energy_tab[i]} << (dbl ? 17 : 16)) / (65536 + frac);
            if (energy > SAT33) energy = SAT33;
            speed = speed_tab[i > 0 ? i - 1 : 0];
            if (dbl) speed = (speed * longint'(SQRT2_Q31) + (64'd1 << 30)) >> 31;
            if (speed > SAT33) speed = SAT33;
            e.polar_angle = t[28:0];
            e.azimuth = az[30:0];
            e.double_charged = dbl;
            e.ion_energy = energy[32:0];
            e.ion_speed = speed[32:0];
            expected_ions.insert(expected_ions.size(), e);
        endfunction

        function void check_ion(ion_t got);
            ion_t e;
            checked++;
            if (expected_ions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected ion beat: polar %0d", got.polar_angle);
                return;
            end
            e = expected_ions.pop_front();
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ion %0d mismatch: exp polar %0d az %0d dbl %0d E %0h v %0h",
                              " / got polar %0d az %0d dbl %0d E %0h v %0h"},
                             checked, e.polar_angle, e.azimuth, e.double_charged,
                             e.ion_energy, e.ion_speed, got.polar_angle, got.azimuth,
                             got.double_charged, got.ion_energy, got.ion_speed);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;
    logic        s_valid = 1'b0;
    wire         s_ready;
    logic        s_op = 1'b0;
    logic [8:0]  s_entry_index = '0;
    logic [31:0] s_entry_cum = '0;
    logic [16:0] s_entry_fraction = '0;
    logic [31:0] s_entry_energy = '0, s_entry_speed = '0;
    logic [31:0] s_rand_angle = '0, s_rand_azimuth = '0, s_rand_charge = '0;
    wire         m_valid;
    logic        m_ready = 1'b0;
    wire  [28:0] m_polar_angle;
    wire  [30:0] m_azimuth;
    wire         m_double_charged;
    wire  [32:0] m_ion_energy, m_ion_speed;

    inverse_cdf_angle_sampler DUT (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_entry_index(s_entry_index), .s_entry_cum(s_entry_cum),
        .s_entry_fraction(s_entry_fraction), .s_entry_energy(s_entry_energy),
        .s_entry_speed(s_entry_speed), .s_rand_angle(s_rand_angle),
        .s_rand_azimuth(s_rand_azimuth), .s_rand_charge(s_rand_charge),
        .m_valid(m_valid), .m_ready(m_ready), .m_polar_angle(m_polar_angle),
        .m_azimuth(m_azimuth), .m_double_charged(m_double_charged),
        .m_ion_energy(m_ion_energy), .m_ion_speed(m_ion_speed)
    );

    ion_scoreboard sb = new();
    longint cycles = 0;
    bit     long_hold_req = 1'b0;
    int     burst_left = 0;
    int     samples_sent = 0, loads_sent = 0, phases_run = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // bound the run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // collect ion beats
    always @(posedge aclk) begin
        ion_t got;
        if (aresetn && m_valid && m_ready) begin
            got.polar_angle = m_polar_angle;
            got.azimuth = m_azimuth;
            got.double_charged = m_double_charged;
            got.ion_energy = m_ion_energy;
            got.ion_speed = m_ion_speed;
            sb.check_ion(got);
        end
    end

    // receiver: stall patterns in stretches, plus one long hold on request
    initial begin
        int mode;
        int left;
        int ph;
        mode = 0;
        left = 0;
        ph = 0;
        forever begin
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_req = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(3);
                    left = $urandom_range(400, 50);
                end
                left--;
                ph++;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= $urandom_range(1);
                    2: m_ready <= ($urandom_range(7) != 0);
                    default: m_ready <= ((ph % 13) < 4);
                endcase
                @(posedge aclk);
            end
        end
    end

    // offer one beat, hold it until taken, then idle per the burst pattern
    task automatic send_beat(beat_t b);
        int gap;
        s_valid <= 1'b1;
        s_op <= b.op;
        s_entry_index <= b.entry_index;
        s_entry_cum <= b.entry_cum;
        s_entry_fraction <= b.entry_fraction;
        s_entry_energy <= b.entry_energy;
        s_entry_speed <= b.entry_speed;
        s_rand_angle <= b.rand_angle;
        s_rand_azimuth <= b.rand_azimuth;
        s_rand_charge <= b.rand_charge;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        sb.note_beat(b);
        if (b.op == OP_SAMPLE) samples_sent++;
        else loads_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(30);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 1);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // drain results, then let any trailing load settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.expected_ions.size() != 0) @(posedge aclk);
        repeat (IDLE_WAIT) @(posedge aclk);
    endtask

    task automatic configure(logic [28:0] bw, logic [8:0] n, logic md, logic [30:0] az);
        wait_idle();
        apb_write(REG_BIN_WIDTH, {3'd0, bw});
        apb_write(REG_BINS_IN_USE, {23'd0, n});
        apb_write(REG_BEAM_MODE, {31'd0, md});
        apb_write(REG_BEAM_AZIMUTH, {1'b0, az});
        phases_run++;
    endtask

    function automatic beat_t load_beat(int idx, logic [31:0] cum);
        beat_t b;
        b = '{default: '0};
        b.op = OP_LOAD;
        b.entry_index = idx[8:0];
        b.entry_cum = cum;
        b.entry_fraction = ($urandom_range(4) == 0) ? 17'd65536 : $urandom_range(65536);
        b.entry_energy = $urandom;
        b.entry_speed = $urandom;
        b.rand_angle = $urandom;
        b.rand_azimuth = $urandom;
        b.rand_charge = $urandom;
        return b;
    endfunction

    function automatic beat_t sample_beat(logic [31:0] ra, logic [31:0] rz, logic [31:0] rc);
        beat_t b;
        b.op = OP_SAMPLE;
        b.entry_index = $urandom;
        b.entry_cum = $urandom;
        b.entry_fraction = $urandom;
        b.entry_energy = $urandom;
        b.entry_speed = $urandom;
        b.rand_angle = ra;
        b.rand_azimuth = rz;
        b.rand_charge = rc;
        return b;
    endfunction

    // fill every table position; kind 0 rising, 1 rising with empty bins, 2 scrambled
    task automatic fill_table(int kind);
        logic [31:0] cum;
        for (int k = 0; k <= TBL_BINS; k++) begin
            case (kind)
                0: cum = k * 32'd16777215 + ((k > 0 && k < TBL_BINS) ? $urandom_range(1000) : 0);
                1: cum = (k / 3) * 32'd50331645;
                default: cum = $urandom;
            endcase
            if (kind != 2 && k == TBL_BINS) cum = 32'hFFFF_FFFF;
            send_beat(load_beat(k, cum));
        end
    endtask

    // draw ions with some table rewrites mixed in
    task automatic random_phase(int count, int max_index);
        beat_t b;
        logic [31:0] ra;
        for (int j = 0; j < count; j++) begin
            if (j == count / 3 && phases_run == 2) long_hold_req = 1'b1;
            if ($urandom_range(6) == 0) begin
                b = load_beat($urandom_range(511), $urandom);
                if ($urandom_range(3) != 0) b.entry_index = $urandom_range(max_index);
                send_beat(b);
            end else begin
                case ($urandom_range(5))
                    0: ra = 32'd0;
                    1: ra = 32'hFFFF_FFFF;
                    2: ra = sb.cum_tab[$urandom_range(max_index)];
                    default: ra = $urandom;
                endcase
                send_beat(sample_beat(ra, $urandom, $urandom));
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, rising table, then the corner draws
        fill_table(0);
        send_beat(load_beat(257, 32'h1234_5678));
        send_beat(load_beat(511, 32'h0));
        send_beat(load_beat(256, 32'hFFFF_FFFF));
        send_beat(sample_beat(32'd0, 32'd0, 32'd0));
        send_beat(sample_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_beat(sample_beat(sb.cum_tab[5], 32'h8000_0000, 32'd0));
        send_beat(sample_beat(sb.cum_tab[128] + 1, 32'd1, 32'hFFFF_FFFF));
        begin
            beat_t b;
            b = load_beat(0, 32'd0);
            b.entry_fraction = 17'd65536;
            b.entry_energy = 32'hFFFF_FFFF;
            b.entry_speed = 32'hFFFF_FFFF;
            send_beat(b);
            b = load_beat(1, sb.cum_tab[1]);
            b.entry_fraction = 17'd0;
            b.entry_energy = 32'hFFFF_FFFF;
            b.entry_speed = 32'hFFFF_FFFF;
            send_beat(b);
        end
        send_beat(sample_beat(32'd1, 32'h5555_5555, 32'hFFFF_FFFF));
        send_beat(sample_beat(sb.cum_tab[1] + 1, 32'hAAAA_AAAA, 32'd0));
        send_beat(sample_beat(sb.cum_tab[2] + 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        random_phase(20, TBL_BINS);

        // narrowest bin, single bin, fixed zero azimuth
        configure(29'd1, 9'd1, 1'b1, 31'd0);
        random_phase(160, 1);

        // widest bins, full table, random azimuth; long receiver hold happens here
        configure(29'd421657428, 9'd256, 1'b0, 31'd1686629713);
        random_phase(160, TBL_BINS);

        // few bins, fixed top azimuth
        configure($urandom_range(421657428, 1), $urandom_range(16, 2), 1'b1, 31'd1686629713);
        random_phase(160, 16);

        // scrambled table
        configure($urandom_range(421657428, 1), $urandom_range(32, 1), 1'b0,
                  $urandom_range(1686629713));
        fill_table(2);
        random_phase(160, 32);

        // empty bins at the default width
        configure(BIN_WIDTH_RST, 9'd256, $urandom_range(1), $urandom_range(1686629713));
        fill_table(1);
        random_phase(160, TBL_BINS);

        wait_idle();
        $display("ran %0d phases: %0d table loads, %0d ion draws, %0d ions checked",
                 phases_run, loads_sent, samples_sent, sb.checked);
        $display("mismatches %0d, ions still owed %0d", sb.mismatches, sb.expected_ions.size());
        if (sb.mismatches == 0 && sb.expected_ions.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+hdl
hdl/icas_pkg.sv
hdl/icas_ram.sv
hdl/inverse_cdf_angle_sampler.sv
verif/tb.sv
